[sv/rotary_switch_iir_hysteresis_debounce_macros.svh]
// Assertion macros for the rotary switch debouncer.
// Each check is compiled away when SYNTHESIS is defined.
`ifndef ROTARY_SWITCH_IIR_HYSTERESIS_DEBOUNCE_MACROS_SVH
`define ROTARY_SWITCH_IIR_HYSTERESIS_DEBOUNCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define RSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under reset.
`define RSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define RSD_ASSERT_NOW(label, clk, rst, ante, cons)
`define RSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/rsd_pkg.sv]
`timescale 1ns / 1ps
package rsd_pkg;

   // Fixed switch count: each switch has its own named field
   localparam int NUM_SWITCHES = 3;
   localparam int LINES_PER_SWITCH_DEFAULT = 4;
   localparam int LEVEL_BITS_DEFAULT = 16;

   // Configuration registers are Q0.16
   localparam int CFG_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CFG_BITS-1:0] WEIGHT_RESET      = 16'd43254;
   localparam logic [CFG_BITS-1:0] THRESH_HIGH_RESET = 16'd45875;
   localparam logic [CFG_BITS-1:0] THRESH_LOW_RESET  = 16'd19661;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WEIGHT      = 2'd0,
      CSR_THRESH_HIGH = 2'd1,
      CSR_THRESH_LOW  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] weight;
      logic [CFG_BITS-1:0] thresh_high;
      logic [CFG_BITS-1:0] thresh_low;
   } cfg_type;

endpackage

[sv/rsd_if.sv]
`timescale 1ns / 1ps

// Raw sample item: code lines of the three switches
interface rsd_req_if #(parameter int LINES = 4);
   logic             valid;
   logic             ready;
   logic [LINES-1:0] power_raw;
   logic [LINES-1:0] control_raw;
   logic [LINES-1:0] user_raw;

   modport source (output valid, power_raw, control_raw, user_raw, input ready);
   modport sink   (input valid, power_raw, control_raw, user_raw, output ready);
endinterface

// Debounced position item
interface rsd_rsp_if #(parameter int LINES = 4);
   logic             valid;
   logic             ready;
   logic [LINES-1:0] power_position;
   logic [LINES-1:0] control_position;
   logic [LINES-1:0] user_position;

   modport source (output valid, power_position, control_position, user_position,
                   input ready);
   modport sink   (input valid, power_position, control_position, user_position,
                   output ready);
endinterface

// Register write channel
interface rsd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rsd_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [rsd_pkg::CFG_BITS-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/rsd_csr.sv]
`timescale 1ns / 1ps
module rsd_csr
   import rsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rsd_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   // Decode the write; drop writes past the last register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_WEIGHT:      cfg_in.weight      = csr_chan.data;
            CSR_THRESH_HIGH: cfg_in.thresh_high = csr_chan.data;
            CSR_THRESH_LOW:  cfg_in.thresh_low  = csr_chan.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight      <= WEIGHT_RESET;
         cfg_ff.thresh_high <= THRESH_HIGH_RESET;
         cfg_ff.thresh_low  <= THRESH_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/rsd_lane.sv]
`timescale 1ns / 1ps
module rsd_lane
   import rsd_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    raw_bit,
   input  logic    update,
   output logic    debounced
);

   localparam int PROD_BITS = LEVEL_BITS + CFG_BITS;
   localparam logic [CFG_BITS-1:0] ROUND_UP = '1;

   logic [LEVEL_BITS-1:0] level_ff;
   logic [LEVEL_BITS-1:0] level_in;
   logic                  bit_ff;
   logic                  bit_in;
   logic [LEVEL_BITS-1:0] delta;
   logic [PROD_BITS-1:0]  product;
   logic [PROD_BITS-1:0]  rounded;
   logic [LEVEL_BITS-1:0] step;
   logic [PROD_BITS-1:0]  level_cmp;
   logic [PROD_BITS-1:0]  high_cmp;
   logic [PROD_BITS-1:0]  low_cmp;

   // Distance to target: all ones for a high line, zero for a low one
   assign delta   = raw_bit ? ~level_ff : level_ff;
   assign product = PROD_BITS'(cfg.weight) * PROD_BITS'(delta);
   // Falling step rounds away from zero; weight below 1.0 keeps the sum in range
   assign rounded = product + PROD_BITS'(ROUND_UP);
   assign step    = raw_bit ? product[PROD_BITS-1:CFG_BITS]
                            : rounded[PROD_BITS-1:CFG_BITS];

   assign level_in = raw_bit ? level_ff + step : level_ff - step;

   // Compare as fractions on a common scale
   assign level_cmp = {level_in, CFG_BITS'(0)};
   assign high_cmp  = {cfg.thresh_high, LEVEL_BITS'(0)};
   assign low_cmp   = {cfg.thresh_low, LEVEL_BITS'(0)};

   // Hysteresis: set test wins when both are crossed
   always_comb begin
      if (level_cmp > high_cmp) begin
         bit_in = 1'b1;
      end else if (level_cmp < low_cmp) begin
         bit_in = 1'b0;
      end else begin
         bit_in = bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         bit_ff   <= 1'b0;
      end else if (update) begin
         level_ff <= level_in;
         bit_ff   <= bit_in;
      end
   end

   assign debounced = bit_ff;

endmodule

[sv/rotary_switch_iir_hysteresis_debounce.sv]
`timescale 1ns / 1ps
// Rotary switch debouncer for three switches.
// req_chan carries one sample tick: the raw code lines of the power, control
// and user switches. rsp_chan returns one item per tick: the debounced
// positions, line i at bit i. csr_chan writes the IIR weight (index 0) and the
// high and low thresholds (indexes 1 and 2); it is always ready, and writes
// belong to idle periods.
// A tick accepted into the input register then takes one pass of the filter lanes
// into the state and result registers, which it enters once the result slot is
// free or being read. Throughput: one tick per cycle while rsp_chan is ready; each of the
// lines has its own 16 x LEVEL_BITS multiplier, which sets the cycle path.
// The result register is the debounced state itself; the input register
// holds one more tick while a result waits, so req_chan stays ready for one
// tick beyond a stalled rsp_chan and then stalls as well.
// Reset clears all filter levels and debounced bits to zero, empties both
// registers and loads the default weight and thresholds.
`include "rotary_switch_iir_hysteresis_debounce_macros.svh"
module rotary_switch_iir_hysteresis_debounce
   import rsd_pkg::*;
#(
   parameter int LINES_PER_SWITCH = LINES_PER_SWITCH_DEFAULT,
   parameter int LEVEL_BITS       = LEVEL_BITS_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   rsd_req_if.sink    req_chan,
   rsd_rsp_if.source  rsp_chan,
   rsd_csr_if.sink    csr_chan
);

   localparam int NUM_LINES = NUM_SWITCHES * LINES_PER_SWITCH;

   cfg_type               cfg;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [NUM_LINES-1:0]  s1_raw_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  advance;
   logic                  req_accept;
   logic [NUM_LINES-1:0]  debounced;

   // Configuration registers
   rsd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Move the held item into the lanes when the result slot is free
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the raw lines, power switch in the low lines
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_raw_ff <= {req_chan.user_raw, req_chan.control_raw, req_chan.power_raw};
      end
   end

   // One filter lane per code line
   for (genvar k = 0; k < NUM_LINES; k++) begin : g_lane
      rsd_lane #(
         .LEVEL_BITS (LEVEL_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg),
         .raw_bit   (s1_raw_ff[k]),
         .update    (advance),
         .debounced (debounced[k])
      );
   end

   // Unpack positions from the lane state
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.power_position   = debounced[LINES_PER_SWITCH-1:0];
   assign rsp_chan.control_position = debounced[2*LINES_PER_SWITCH-1:LINES_PER_SWITCH];
   assign rsp_chan.user_position    = debounced[3*LINES_PER_SWITCH-1:2*LINES_PER_SWITCH];

   // A blocked item stays in the input register
   `RSD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance,
                    s1_valid_ff && $stable(s1_raw_ff))
   // Every item passed to the lanes shows up as a result
   `RSD_ASSERT_NEXT(a_advance_rsp, clock, reset, advance, rsp_valid_ff)
   // Lane state moves only when an item is processed
   `RSD_ASSERT_NEXT(a_state_hold, clock, reset, !advance, $stable(debounced))
   // Never accept into a full input register that is not draining
   `RSD_ASSERT_NOW(a_no_overrun, clock, reset, req_accept && s1_valid_ff, advance)

endmodule

[tb/rotary_switch_iir_hysteresis_debounce_tb.sv]
`timescale 1ns / 1ps
module rotary_switch_iir_hysteresis_debounce_tb;
   import rsd_pkg::*;

   localparam int LINES = LINES_PER_SWITCH_DEFAULT;
   localparam int LEVEL_W = LEVEL_BITS_DEFAULT;
   localparam int NUM_LANES = NUM_SWITCHES * LINES;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;
   // Item window in which neither side idles
   localparam int CALM_FIRST = 500;
   localparam int CALM_LAST = 800;
   localparam int IDLE_PERCENT = 18;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [LINES-1:0] power;
      logic [LINES-1:0] control;
      logic [LINES-1:0] user;
   } sample_type;

   typedef struct packed {
      logic [LINES-1:0] power;
      logic [LINES-1:0] control;
      logic [LINES-1:0] user;
   } position_type;

   logic clock = 1'b0;
   logic reset;

   rsd_req_if #(.LINES(LINES)) req ();
   rsd_rsp_if #(.LINES(LINES)) rsp ();
   rsd_csr_if csr ();

   rotary_switch_iir_hysteresis_debounce #(
      .LINES_PER_SWITCH(LINES),
      .LEVEL_BITS(LEVEL_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp),
      .csr_chan(csr)
   );

   always #5 clock = ~clock;

   // Shadow of the filter state and the registers
   cfg_type cfg_shadow;
   logic [LEVEL_W-1:0] lane_level [NUM_LANES];
   logic lane_bit [NUM_LANES];

   sample_type pending_samples [$];
   position_type expected_positions [$];
   sample_type on_bus;
   position_type want;
   int sent_count = 0;
   int error_count = 0;

   // Advance the filter lanes of one switch and return its debounced position
   function automatic logic [LINES-1:0] filter_switch(int sw, logic [LINES-1:0] raw);
      logic [LINES-1:0] pos;
      logic [LEVEL_W-1:0] y;
      logic [LEVEL_W-1:0] span;
      logic [31:0] prod;
      logic [31:0] round_up;
      int k;
      for (int l = 0; l < LINES; l++) begin
         k = sw * LINES + l;
         y = lane_level[k];
         if (raw[l]) begin
            span = {LEVEL_W{1'b1}} - y;
            prod = cfg_shadow.weight * span;
            y = y + prod[31:16];
         end else begin
            // falling step rounds away from zero
            span = y;
            prod = cfg_shadow.weight * span;
            round_up = prod + 32'h0000_FFFF;
            y = y - round_up[31:16];
         end
         lane_level[k] = y;
         // set test wins when both thresholds are crossed
         if (y > cfg_shadow.thresh_high) begin
            lane_bit[k] = 1'b1;
         end else if (y < cfg_shadow.thresh_low) begin
            lane_bit[k] = 1'b0;
         end
         pos[l] = lane_bit[k];
      end
      return pos;
   endfunction

   function automatic position_type debounce_sample(sample_type s);
      position_type p;
      p.power = filter_switch(0, s.power);
      p.control = filter_switch(1, s.control);
      p.user = filter_switch(2, s.user);
      return p;
   endfunction

   function automatic bit draw_gap();
      if (sent_count >= CALM_FIRST && sent_count < CALM_LAST) begin
         return 1'b0;
      end
      return $urandom_range(99, 0) < IDLE_PERCENT;
   endfunction

   function automatic void check_field(string name, logic [LINES-1:0] exp_val,
                                       logic [LINES-1:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, got_val);
         error_count++;
      end
   endfunction

   // Drive sample items from the pending queue, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_positions.push_back(debounce_sample(on_bus));
            sent_count <= sent_count + 1;
         end
         if (!req.valid || req.ready) begin
            if (pending_samples.size() != 0 && !draw_gap()) begin
               on_bus = pending_samples.pop_front();
               req.valid <= 1'b1;
               req.power_raw <= on_bus.power;
               req.control_raw <= on_bus.control;
               req.user_raw <= on_bus.user;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Check each accepted position item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_positions.size() == 0) begin
               $display("%0t: unexpected item, expected none actual %h %h %h", $time,
                        rsp.power_position, rsp.control_position, rsp.user_position);
               error_count++;
            end else begin
               want = expected_positions.pop_front();
               check_field("power_position", want.power, rsp.power_position);
               check_field("control_position", want.control, rsp.control_position);
               check_field("user_position", want.user, rsp.user_position);
            end
         end
         rsp.ready <= !draw_gap();
      end
   end

   task automatic add_tick(logic [LINES-1:0] p, logic [LINES-1:0] c, logic [LINES-1:0] u);
      sample_type s;
      s.power = p;
      s.control = c;
      s.user = u;
      pending_samples.push_back(s);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (idx)
         CSR_WEIGHT: cfg_shadow.weight = value;
         CSR_THRESH_HIGH: cfg_shadow.thresh_high = value;
         CSR_THRESH_LOW: cfg_shadow.thresh_low = value;
         default: ;
      endcase
      csr.valid <= 1'b0;
   endtask

   task automatic load_config(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] hi,
                              logic [CFG_BITS-1:0] lo);
      write_reg(CSR_WEIGHT, w);
      write_reg(CSR_THRESH_HIGH, hi);
      write_reg(CSR_THRESH_LOW, lo);
   endtask

   // Wait until every item is out and the block has drained
   task automatic wait_idle();
      while (pending_samples.size() != 0 || req.valid || expected_positions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Switch turns: hold a position for a run of ticks, with contact bounce
   // at the start of each run and some pure noise ticks in between
   task automatic run_random(int count, int max_run);
      logic [LINES-1:0] target [NUM_SWITCHES];
      logic [LINES-1:0] v [NUM_SWITCHES];
      int run_len;
      int n;
      n = 0;
      foreach (target[s]) target[s] = LINES'($urandom_range(15, 0));
      while (n < count) begin
         if ($urandom_range(99, 0) < 15) begin
            add_tick(LINES'($urandom_range(15, 0)), LINES'($urandom_range(15, 0)),
                     LINES'($urandom_range(15, 0)));
            n++;
         end else begin
            foreach (target[s]) begin
               if ($urandom_range(1, 0)) target[s] = LINES'($urandom_range(15, 0));
            end
            run_len = $urandom_range(max_run, 2);
            for (int k = 0; k < run_len && n < count; k++) begin
               foreach (v[s]) begin
                  v[s] = target[s];
                  if (k < 3 && $urandom_range(99, 0) < 40) v[s] ^= LINES'($urandom_range(15, 1));
               end
               add_tick(v[0], v[1], v[2]);
               n++;
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.power_raw = '0;
      req.control_raw = '0;
      req.user_raw = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      cfg_shadow.weight = WEIGHT_RESET;
      cfg_shadow.thresh_high = THRESH_HIGH_RESET;
      cfg_shadow.thresh_low = THRESH_LOW_RESET;
      foreach (lane_level[k]) begin
         lane_level[k] = '0;
         lane_bit[k] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset weight and thresholds: rise, fall and mixed codes
      add_tick(4'h0, 4'h0, 4'h0);
      repeat (5) add_tick(4'hF, 4'hF, 4'hF);
      repeat (4) add_tick(4'h0, 4'h0, 4'h0);
      repeat (2) add_tick(4'h5, 4'hA, 4'h3);
      repeat (2) add_tick(4'hA, 4'h5, 4'hC);
      run_random(350, 10);
      wait_idle();

      // Full weight, low threshold above high one: set test wins
      load_config(16'hFFFF, 16'h0000, 16'hFFFF);
      add_tick(4'hF, 4'h0, 4'h5);
      add_tick(4'h0, 4'hF, 4'hA);
      add_tick(4'h5, 4'hA, 4'h0);
      add_tick(4'h0, 4'h0, 4'hF);
      run_random(100, 4);
      wait_idle();

      // Write to an unmapped index is dropped; zero weight freezes the levels
      write_reg(CSR_UNMAPPED, CFG_BITS'($urandom_range(65535, 0)));
      load_config(16'h0000, 16'hFFFF, 16'h0000);
      run_random(40, 6);
      wait_idle();

      // Smallest moving weight around mid-scale thresholds
      load_config(16'h0001, 16'h8000, 16'h7FFF);
      run_random(60, 20);
      wait_idle();

      // Random settings
      repeat (5) begin
         load_config(CFG_BITS'($urandom_range(65535, 2000)), CFG_BITS'($urandom_range(65535, 0)),
                     CFG_BITS'($urandom_range(65535, 0)));
         run_random(160, 12);
         wait_idle();
      end

      // Back to reset values
      load_config(WEIGHT_RESET, THRESH_HIGH_RESET, THRESH_LOW_RESET);
      run_random(80, 10);
      wait_idle();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
